/* rtl/clt_pkg.sv */
`default_nettype none

package clt_pkg;

	// Byte codes the tokenizer reacts to
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Depth of the queue between front and back, and of the result queue
	localparam int unsigned Q_DEPTH = 2;

	// One classified input byte
	typedef struct packed {
		logic [7:0] data;
		logic       is_zero;   // end of line
		logic       is_quote;
		logic       is_slash;
		logic       is_blank;  // space or tab
		logic       is_ctl;    // unsigned value of space or below
	} item_t;

	// One result
	typedef struct packed {
		logic [7:0] slash_run;
		logic [7:0] char_out;
		logic       char_valid;
		logic       arg_end;
		logic       line_end;
		logic [9:0] arg_index;
	} result_t;

endpackage

`default_nettype wire

/* rtl/command_line_tokenizer_core.sv */
`default_nettype none

// Command line tokenizer.
// Input channel: drive in_byte and raise push; the byte transfers on a clock
// edge where push is high and full is low. A zero byte ends the line.
// Result channel: while empty is low the oldest result sits on slash_run,
// char_out, char_valid, arg_end, line_end and arg_index; it transfers on a
// clock edge where pop is high. The consumer appends slash_run backslashes,
// then char_out when char_valid is set. Bytes that add nothing (backslashes
// being counted, separators between arguments) give no result.
// Throughput: one byte per cycle while the consumer keeps popping. A byte is
// classified by the front end into a two-entry queue; the back end runs the
// tokenizer state on each byte and writes a two-entry result queue.
// A result is written to the result queue as the back end takes its byte.
// When the consumer stalls, the result queue fills, the back end holds, and
// full rises once the input queue is also full; nothing is dropped.
// Reset: arst_n clears both queues and the tokenizer state at once; the
// block is ready for the first byte of a new line right after reset.
module command_line_tokenizer_core #(
	parameter int unsigned MAX_SLASHES = 255,
	parameter int unsigned MAX_ARGS    = 1023
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire  [7:0] in_byte,
	output logic       empty,
	input  wire        pop,
	output logic [7:0] slash_run,
	output logic [7:0] char_out,
	output logic       char_valid,
	output logic       arg_end,
	output logic       line_end,
	output logic [9:0] arg_index
);

	clt_pkg::item_t   fe_item;
	clt_pkg::item_t   be_item;
	clt_pkg::result_t be_res;
	clt_pkg::result_t out_res;
	logic             fe_push;
	logic             iq_full;
	logic             iq_empty;
	logic             be_take;
	logic             be_push;
	logic             rq_full;

	// Front end: classify and queue
	clt_front u_front (
		.push    (push),
		.in_byte (in_byte),
		.full    (full),
		.q_full  (iq_full),
		.q_push  (fe_push),
		.item    (fe_item)
	);

	clt_fifo #(
		.DEPTH (clt_pkg::Q_DEPTH),
		.T     (clt_pkg::item_t)
	) u_item_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_push),
		.data_in  (fe_item),
		.full     (iq_full),
		.pop      (be_take),
		.data_out (be_item),
		.empty    (iq_empty)
	);

	// Back end: tokenizer state machine
	clt_back #(
		.MAX_SLASHES (MAX_SLASHES),
		.MAX_ARGS    (MAX_ARGS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (be_item),
		.item_valid (!iq_empty),
		.item_take  (be_take),
		.res_push   (be_push),
		.res        (be_res),
		.res_full   (rq_full)
	);

	// Result queue
	clt_fifo #(
		.DEPTH (clt_pkg::Q_DEPTH),
		.T     (clt_pkg::result_t)
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (be_push),
		.data_in  (be_res),
		.full     (rq_full),
		.pop      (pop),
		.data_out (out_res),
		.empty    (empty)
	);

	assign slash_run  = out_res.slash_run;
	assign char_out   = out_res.char_out;
	assign char_valid = out_res.char_valid;
	assign arg_end    = out_res.arg_end;
	assign line_end   = out_res.line_end;
	assign arg_index  = out_res.arg_index;

endmodule

`default_nettype wire

/* rtl/clt_fifo.sv */
`default_nettype none

module clt_fifo #(
	parameter int unsigned DEPTH = 2,
	parameter type T = logic
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  T     data_in,
	output logic full,
	input  wire  pop,
	output T     data_out,
	output logic empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo count above depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("fifo empty after a lone push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("fifo pointers disagree with count");
`endif

endmodule

`default_nettype wire

/* rtl/clt_front.sv */
`default_nettype none

module clt_front (
	input  wire          push,
	input  wire  [7:0]   in_byte,
	output logic         full,
	input  wire          q_full,
	output logic         q_push,
	output clt_pkg::item_t item
);

	// Transfer goes straight into the queue while it has room
	assign full   = q_full;
	assign q_push = push && !q_full;

	// Classify the byte once, so the back end only tests flags
	always_comb begin
		item.data     = in_byte;
		item.is_zero  = (in_byte == clt_pkg::CH_NUL);
		item.is_quote = (in_byte == clt_pkg::CH_QUOTE);
		item.is_slash = (in_byte == clt_pkg::CH_SLASH);
		item.is_blank = (in_byte == clt_pkg::CH_SPACE) || (in_byte == clt_pkg::CH_TAB);
		item.is_ctl   = (in_byte <= clt_pkg::CH_SPACE);
	end

endmodule

`default_nettype wire

/* rtl/clt_back.sv */
`default_nettype none

module clt_back #(
	parameter int unsigned MAX_SLASHES = 255,
	parameter int unsigned MAX_ARGS    = 1023
) (
	input  wire             clk,
	input  wire             arst_n,
	input  clt_pkg::item_t  item,
	input  wire             item_valid,
	output logic            item_take,
	output logic            res_push,
	output clt_pkg::result_t res,
	input  wire             res_full
);

	localparam int unsigned SW = $clog2(MAX_SLASHES + 1);
	localparam int unsigned AW = $clog2(MAX_ARGS + 1);

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_QNAME = 2'd1;
	localparam logic [1:0] PH_TOKEN = 2'd2;
	localparam logic [1:0] PH_GAP   = 2'd3;

	logic [1:0]    phase_q, phase_d;
	logic          inq_q, inq_d;
	logic          qp_q, qp_d;
	logic [SW-1:0] slash_q, slash_d;
	logic [AW-1:0] arg_q, arg_d;

	logic          emit, cv, ae, le;
	logic [7:0]    ch;
	logic [SW-1:0] run;
	logic [SW-1:0] n;
	logic          do_name, quoted, do_arg, arg_done, inq_l, nxt, restart;
	logic [SW+7:0] run_ext;
	logic [AW+9:0] arg_ext;

	assign item_take = item_valid && !res_full;
	assign res_push  = item_take && emit;
	assign run_ext   = {8'b0, run};
	assign arg_ext   = {10'b0, arg_q};

	always_comb begin
		res.slash_run  = run_ext[7:0];
		res.char_out   = ch;
		res.char_valid = cv;
		res.arg_end    = ae;
		res.line_end   = le;
		res.arg_index  = arg_ext[9:0];
	end

	// Next state and result for one byte
	always_comb begin
		phase_d  = phase_q;
		inq_d    = inq_q;
		qp_d     = qp_q;
		slash_d  = slash_q;
		arg_d    = arg_q;
		emit     = 1'b0;
		cv       = 1'b0;
		ae       = 1'b0;
		le       = 1'b0;
		ch       = '0;
		run      = '0;
		n        = '0;
		do_name  = 1'b0;
		quoted   = 1'b0;
		do_arg   = 1'b0;
		arg_done = 1'b0;
		inq_l    = inq_q;
		nxt      = 1'b0;
		restart  = 1'b0;

		// Dispatch on phase
		case (phase_q)
			PH_START: begin
				if (item.is_quote) begin
					phase_d = PH_QNAME;
				end else begin
					if (!item.is_ctl) begin
						phase_d = PH_TOKEN;
					end
					do_name = 1'b1;
				end
			end
			PH_QNAME: begin
				do_name = 1'b1;
				quoted  = 1'b1;
			end
			PH_TOKEN: begin
				if (arg_q == '0) begin
					do_name = 1'b1;
				end else begin
					do_arg = 1'b1;
				end
			end
			default: begin
				if (item.is_blank) begin
					// skip separators
				end else if (item.is_zero) begin
					emit    = 1'b1;
					le      = 1'b1;
					restart = 1'b1;
				end else begin
					phase_d = PH_TOKEN;
					do_arg  = 1'b1;
				end
			end
		endcase

		// Program name: no escapes
		if (do_name) begin
			emit = 1'b1;
			if (item.is_zero) begin
				ae      = 1'b1;
				le      = 1'b1;
				restart = 1'b1;
			end else if (quoted ? item.is_quote : item.is_ctl) begin
				ae  = 1'b1;
				nxt = 1'b1;
			end else begin
				ch = item.data;
				cv = 1'b1;
			end
		end

		// Later arguments: backslash and quote rules
		if (do_arg) begin
			if (qp_q) begin
				qp_d  = 1'b0;
				inq_l = 1'b0;
				inq_d = 1'b0;
				if (item.is_quote) begin
					emit     = 1'b1;
					ch       = clt_pkg::CH_QUOTE;
					cv       = 1'b1;
					arg_done = 1'b1;
				end
			end
			if (!arg_done) begin
				if (item.is_slash) begin
					if (slash_q < SW'(MAX_SLASHES)) begin
						slash_d = slash_q + SW'(1);
					end
				end else begin
					n       = slash_q;
					slash_d = '0;
					if (item.is_quote) begin
						if (n[0]) begin
							emit = 1'b1;
							run  = n >> 1;
							ch   = clt_pkg::CH_QUOTE;
							cv   = 1'b1;
						end else begin
							if (inq_l) begin
								qp_d = 1'b1;
							end else begin
								inq_d = 1'b1;
							end
							if ((n >> 1) != '0) begin
								emit = 1'b1;
								run  = n >> 1;
							end
						end
					end else if (item.is_zero) begin
						emit    = 1'b1;
						run     = n;
						ae      = 1'b1;
						le      = 1'b1;
						restart = 1'b1;
					end else if (!inq_l && item.is_blank) begin
						emit = 1'b1;
						run  = n;
						ae   = 1'b1;
						nxt  = 1'b1;
					end else begin
						emit = 1'b1;
						run  = n;
						ch   = item.data;
						cv   = 1'b1;
					end
				end
			end
		end

		// Argument finished
		if (nxt) begin
			if (arg_q < AW'(MAX_ARGS)) begin
				arg_d = arg_q + AW'(1);
			end
			phase_d = PH_GAP;
			inq_d   = 1'b0;
			qp_d    = 1'b0;
			slash_d = '0;
		end

		// Line finished: back to reset state
		if (restart) begin
			phase_d = PH_START;
			inq_d   = 1'b0;
			qp_d    = 1'b0;
			slash_d = '0;
			arg_d   = '0;
		end
	end

	// Tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			inq_q   <= 1'b0;
			qp_q    <= 1'b0;
			slash_q <= '0;
			arg_q   <= '0;
		end else if (item_take) begin
			phase_q <= phase_d;
			inq_q   <= inq_d;
			qp_q    <= qp_d;
			slash_q <= slash_d;
			arg_q   <= arg_d;
		end
	end

`ifndef SYNTHESIS
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.line_end) |=>
		(phase_q == PH_START && arg_q == '0 && slash_q == '0 && !inq_q && !qp_q))
		else $error("state not cleared after line end");
	a_pending_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		qp_q |-> (inq_q && phase_q == PH_TOKEN))
		else $error("quote pending outside a quoted token");
	a_slash_sat: assert property (@(posedge clk) disable iff (!arst_n)
		slash_q <= SW'(MAX_SLASHES))
		else $error("backslash count above saturation");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");
`endif

endmodule

`default_nettype wire

/* tb/command_line_tokenizer_core_tb.sv */
module command_line_tokenizer_core_tb;

	localparam int unsigned SLASH_LIMIT = 255;
	localparam int unsigned ARG_LIMIT   = 1023;
	localparam int unsigned RANDOM_BYTES = 230;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	// predicted tokenizer phase
	localparam logic [1:0] PH_NAME_START  = 2'd0;
	localparam logic [1:0] PH_QUOTED_NAME = 2'd1;
	localparam logic [1:0] PH_IN_TOKEN    = 2'd2;
	localparam logic [1:0] PH_BETWEEN     = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] in_byte;
	logic       empty;
	logic       pop;
	logic [7:0] slash_run;
	logic [7:0] char_out;
	logic       char_valid;
	logic       arg_end;
	logic       line_end;
	logic [9:0] arg_index;

	// tokenizer state as predicted
	logic [1:0]  tk_phase;
	bit          tk_in_quotes;
	bit          tk_quote_pending;
	int unsigned tk_slashes;
	int unsigned tk_arg_idx;

	clt_pkg::result_t expected_pieces[$];
	clt_pkg::result_t oldest_piece;
	int unsigned errors;
	int unsigned bytes_sent;
	int unsigned cycle_count;
	bit          no_idle;

	command_line_tokenizer_core #(
		.MAX_SLASHES(SLASH_LIMIT),
		.MAX_ARGS   (ARG_LIMIT)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.empty     (empty),
		.pop       (pop),
		.slash_run (slash_run),
		.char_out  (char_out),
		.char_valid(char_valid),
		.arg_end   (arg_end),
		.line_end  (line_end),
		.arg_index (arg_index)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------- tokenizer prediction ----------------

	function automatic void restart_line();
		tk_phase         = PH_NAME_START;
		tk_in_quotes     = 1'b0;
		tk_quote_pending = 1'b0;
		tk_slashes       = 0;
		tk_arg_idx       = 0;
	endfunction

	function automatic void advance_arg();
		if (tk_arg_idx < ARG_LIMIT)
			tk_arg_idx++;
		tk_phase         = PH_BETWEEN;
		tk_in_quotes     = 1'b0;
		tk_quote_pending = 1'b0;
		tk_slashes       = 0;
	endfunction

	function automatic clt_pkg::result_t make_piece(input int unsigned run,
			input logic [7:0] ch, input bit valid, input bit aend, input bit lend);
		clt_pkg::result_t p;
		p.slash_run  = run[7:0];
		p.char_out   = valid ? ch : 8'h00;
		p.char_valid = valid;
		p.arg_end    = aend;
		p.line_end   = lend;
		p.arg_index  = tk_arg_idx[9:0];
		return p;
	endfunction

	// program name bytes, quoted or not
	function automatic bit name_piece(input logic [7:0] b, input bit quoted,
			output clt_pkg::result_t p);
		if (b == clt_pkg::CH_NUL) begin
			p = make_piece(0, 8'h00, 1'b0, 1'b1, 1'b1);
			restart_line();
		end else if (quoted ? (b == clt_pkg::CH_QUOTE) : (b <= clt_pkg::CH_SPACE)) begin
			p = make_piece(0, 8'h00, 1'b0, 1'b1, 1'b0);
			advance_arg();
		end else begin
			p = make_piece(0, b, 1'b1, 1'b0, 1'b0);
		end
		return 1'b1;
	endfunction

	// bytes of argument 1 and above: backslash and quote rules
	function automatic bit arg_piece(input logic [7:0] b, output clt_pkg::result_t p);
		int unsigned n;
		p = '0;
		if (tk_quote_pending) begin
			tk_quote_pending = 1'b0;
			tk_in_quotes     = 1'b0;
			if (b == clt_pkg::CH_QUOTE) begin
				p = make_piece(0, clt_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
				return 1'b1;
			end
		end
		if (b == clt_pkg::CH_SLASH) begin
			if (tk_slashes < SLASH_LIMIT)
				tk_slashes++;
			return 1'b0;
		end
		n = tk_slashes;
		tk_slashes = 0;
		if (b == clt_pkg::CH_QUOTE) begin
			if (n[0]) begin
				p = make_piece(n >> 1, clt_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
				return 1'b1;
			end
			if (tk_in_quotes)
				tk_quote_pending = 1'b1;
			else
				tk_in_quotes = 1'b1;
			if ((n >> 1) == 0)
				return 1'b0;
			p = make_piece(n >> 1, 8'h00, 1'b0, 1'b0, 1'b0);
			return 1'b1;
		end
		if (b == clt_pkg::CH_NUL) begin
			p = make_piece(n, 8'h00, 1'b0, 1'b1, 1'b1);
			restart_line();
			return 1'b1;
		end
		if (!tk_in_quotes && (b == clt_pkg::CH_SPACE || b == clt_pkg::CH_TAB)) begin
			p = make_piece(n, 8'h00, 1'b0, 1'b1, 1'b0);
			advance_arg();
			return 1'b1;
		end
		p = make_piece(n, b, 1'b1, 1'b0, 1'b0);
		return 1'b1;
	endfunction

	function automatic bit tokenize_byte(input logic [7:0] b, output clt_pkg::result_t p);
		p = '0;
		case (tk_phase)
			PH_NAME_START: begin
				if (b == clt_pkg::CH_QUOTE) begin
					tk_phase = PH_QUOTED_NAME;
					return 1'b0;
				end
				if (b > clt_pkg::CH_SPACE)
					tk_phase = PH_IN_TOKEN;
				return name_piece(b, 1'b0, p);
			end
			PH_QUOTED_NAME:
				return name_piece(b, 1'b1, p);
			PH_IN_TOKEN: begin
				if (tk_arg_idx == 0)
					return name_piece(b, 1'b0, p);
				return arg_piece(b, p);
			end
			default: begin
				if (b == clt_pkg::CH_SPACE || b == clt_pkg::CH_TAB)
					return 1'b0;
				if (b == clt_pkg::CH_NUL) begin
					p = make_piece(0, 8'h00, 1'b0, 1'b0, 1'b1);
					restart_line();
					return 1'b1;
				end
				tk_phase = PH_IN_TOKEN;
				return arg_piece(b, p);
			end
		endcase
	endfunction

	// ---------------- traffic ----------------

	// mostly no gap, some short, a few long
	function automatic int unsigned idle_length();
		int unsigned roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side: bursts of pop with random stalls
	initial begin
		int unsigned burst;
		int unsigned stall;
		pop = 1'b0;
		forever begin
			burst = $urandom_range(1, 20);
			repeat (burst) @(negedge clk) pop <= 1'b1;
			stall = idle_length();
			repeat (stall) @(negedge clk) pop <= 1'b0;
		end
	end

	// one byte transfer, then predict what it causes
	task automatic send_byte(input logic [7:0] b);
		int unsigned      gap;
		clt_pkg::result_t piece;
		gap = idle_length();
		repeat (gap) begin
			@(negedge clk);
			push    <= 1'b0;
			in_byte <= 8'($urandom_range(0, 255));
		end
		@(negedge clk);
		push    <= 1'b1;
		in_byte <= b;
		do
			@(posedge clk);
		while (full !== 1'b0);
		bytes_sent++;
		if (tokenize_byte(b, piece))
			expected_pieces.push_back(piece);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line(input string s);
		send_text(s);
		send_byte(clt_pkg::CH_NUL);
	endtask

	// result checking
	function automatic void check_field(input string name, input logic [9:0] want,
			input logic [9:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0) begin
			if (expected_pieces.size() == 0) begin
				$display("%0t: result with nothing expected: slash_run %0d char_out %0d",
					$time, slash_run, char_out);
				$display("    char_valid %0b arg_end %0b line_end %0b arg_index %0d",
					char_valid, arg_end, line_end, arg_index);
				errors++;
			end else begin
				oldest_piece = expected_pieces.pop_front();
				check_field("slash_run", 10'(oldest_piece.slash_run), 10'(slash_run));
				check_field("char_out", 10'(oldest_piece.char_out), 10'(char_out));
				check_field("char_valid", 10'(oldest_piece.char_valid), 10'(char_valid));
				check_field("arg_end", 10'(oldest_piece.arg_end), 10'(arg_end));
				check_field("line_end", 10'(oldest_piece.line_end), 10'(line_end));
				check_field("arg_index", oldest_piece.arg_index, arg_index);
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_program_names();
		send_line("prog a b");
		send_line("\"my prog\"x y");
		send_line("\"unclosed name");
		send_line(" a");
		send_byte(clt_pkg::CH_NUL);
		send_byte(8'h01);
		send_byte(clt_pkg::CH_NUL);
		// high bytes stay in an unquoted name
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h21);
		send_byte(8'h7F);
		send_byte(clt_pkg::CH_NUL);
	endtask

	task automatic test_quote_rules();
		send_line("p a\\\\\"b c\" d");
		send_line("p a\\\"b");
		send_line("p \"x\"\"y\" z");
		send_line("p \\\\x \"open");
		send_line("p a\\\\");
		send_line("p a \t ");
	endtask

	// saturated count, then a quote that sees its parity
	task automatic test_slash_saturation();
		send_text("p ");
		repeat (260) send_byte(clt_pkg::CH_SLASH);
		send_byte(clt_pkg::CH_QUOTE);
		send_line("z");
	endtask

	task automatic send_blanks();
		repeat ($urandom_range(1, 3))
			send_byte($urandom_range(0, 1) ? clt_pkg::CH_SPACE : clt_pkg::CH_TAB);
	endtask

	task automatic send_random_arg();
		int unsigned n;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 7))
				0, 1: send_byte(8'($urandom_range(33, 255)));
				2: begin
					n = $urandom_range(1, 5);
					repeat (n) send_byte(clt_pkg::CH_SLASH);
					send_byte(clt_pkg::CH_QUOTE);
				end
				3: begin
					n = $urandom_range(1, 5);
					repeat (n) send_byte(clt_pkg::CH_SLASH);
					send_byte(8'($urandom_range(33, 255)));
				end
				4: send_byte(clt_pkg::CH_QUOTE);
				5: begin
					send_byte(clt_pkg::CH_QUOTE);
					send_byte(clt_pkg::CH_QUOTE);
				end
				6: begin
					send_byte(clt_pkg::CH_QUOTE);
					repeat ($urandom_range(0, 4))
						send_byte($urandom_range(0, 3) == 0 ? clt_pkg::CH_SPACE :
							8'($urandom_range(1, 255)));
					send_byte(clt_pkg::CH_QUOTE);
				end
				default: begin
					n = $urandom_range(1, 3);
					repeat (n) send_byte(clt_pkg::CH_SLASH);
				end
			endcase
		end
	endtask

	task automatic send_random_line();
		int unsigned nargs;
		no_idle = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 9) == 0) begin
			// noise: any nonzero bytes
			repeat ($urandom_range(1, 16)) send_byte(8'($urandom_range(1, 255)));
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					send_byte(clt_pkg::CH_QUOTE);
					repeat ($urandom_range(0, 6)) begin
						send_byte($urandom_range(0, 4) == 0 ? clt_pkg::CH_SPACE :
							8'($urandom_range(35, 255)));
					end
					if ($urandom_range(0, 5) != 0)
						send_byte(clt_pkg::CH_QUOTE);
				end
				1: send_byte(8'($urandom_range(1, 32)));
				default: begin
					repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(33, 255)));
					send_byte(8'($urandom_range(1, 32)));
				end
			endcase
			nargs = $urandom_range(0, 5);
			repeat (nargs) begin
				send_blanks();
				send_random_arg();
			end
			if ($urandom_range(0, 3) == 0)
				send_blanks();
		end
		send_byte(clt_pkg::CH_NUL);
		no_idle = 1'b0;
	endtask

	task automatic test_random_lines();
		int unsigned start_count;
		start_count = bytes_sent;
		while (bytes_sent - start_count < RANDOM_BYTES)
			send_random_line();
	endtask

	task automatic finish_traffic();
		@(negedge clk);
		push <= 1'b0;
		while (expected_pieces.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		in_byte     = 8'h00;
		errors      = 0;
		bytes_sent  = 0;
		cycle_count = 0;
		no_idle     = 1'b0;
		restart_line();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_program_names();
		test_quote_rules();
		test_slash_saturation();
		test_random_lines();
		finish_traffic();

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
